// File: rtl/tfhn_pkg.sv
// shared types and constants for the triangle floor height and normal unit
// no dependencies; used by the top level, the multiplier and the divider
package tfhn_pkg;

  // shared multiplier operand and product widths
  localparam int MulAW  = 21;
  localparam int MulBW  = 17;
  localparam int ProdW  = MulAW + MulBW;

  // divider widths: wrapped plane numerator and normal y
  localparam int NumW   = 32;
  localparam int DenW   = 21;

  // command codes
  localparam logic [1:0] CMD_TABLE  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_MAG,
    ST_NORM,
    ST_TRD,
    ST_SCALE,
    ST_CROSS,
    ST_PLANE,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// File: rtl/triangle_floor_height_normal_unit.sv
// top level: triangle floor probe giving height and surface normal at a query point
// depends on tfhn_pkg, tfhn_mul (shared multiplier) and tfhn_div (iterative divider)
//
//   channel  | dir | tdata                                  | tuser
//   s_axis   | in  | table, corner and query fields (112b)  | cmd
//   m_axis   | out | inside, height, normal, fault (88b)    | -
//
// table and corner writes give no transfer on m_axis
// an evaluation of an inside point runs 29 products on the one multiplier, a shift
// search per nonzero edge and a division; an outside point, a fault, a zero-length
// edge or a flat normal ends it sooner
// s_axis_tready is high only while idle; rst is synchronous; table and corners start undefined
// a stalled m_axis holds its result; a following result waits in the final step
module triangle_floor_height_normal_unit #(
  parameter int TABLE_DEPTH = 192
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // table_slot[7:0] table_word[23:8] vertex_slot[25:24] corner_x[41:26]
  // corner_y[57:42] corner_z[73:58] query_x[89:74] query_z[105:90], zero pad
  input  logic [111:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // inside_res[0] height[16:1] normal_x[37:17] normal_y[58:38]
  // normal_z[79:59] fault[80], zero pad
  output logic [87:0]  m_axis_tdata
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  // input fields
  logic [1:0]         cmd;
  logic [7:0]         table_slot;
  logic signed [15:0] table_word;
  logic [1:0]         vertex_slot;
  logic signed [15:0] corner_x, corner_y, corner_z, query_x, query_z;

  assign cmd         = s_axis_tuser;
  assign table_slot  = s_axis_tdata[7:0];
  assign table_word  = s_axis_tdata[23:8];
  assign vertex_slot = s_axis_tdata[25:24];
  assign corner_x    = s_axis_tdata[41:26];
  assign corner_y    = s_axis_tdata[57:42];
  assign corner_z    = s_axis_tdata[73:58];
  assign query_x     = s_axis_tdata[89:74];
  assign query_z     = s_axis_tdata[105:90];

  tfhn_pkg::state_t state, state_next;

  // sequencer control
  logic        accept;
  logic        issue, phase_end, div_start, out_load;
  logic [3:0]  last_tag;
  logic [3:0]  cnt, tag;
  logic        pend;
  logic        esel;           // 0: edge corner0->corner1, 1: corner0->corner2

  // state
  logic signed [15:0] vert [3][3];      // [corner][x,y,z]
  logic signed [15:0] recip_mem [TABLE_DEPTH];
  logic signed [15:0] rdata;
  logic signed [15:0] qx, qz;

  // working registers
  logic [31:0]        acc, mag, w;
  logic [3:0]         k;
  logic signed [15:0] nab [3];
  logic signed [15:0] nac [3];
  logic signed [20:0] nrm [3];
  logic signed [31:0] tmp;
  logic [31:0]        pl;
  logic               in_tri, fault;
  logic [15:0]        height_r;
  logic               m_valid;
  logic [87:0]        m_data;

  // shared units
  logic signed [tfhn_pkg::MulAW-1:0] op_a;
  logic signed [tfhn_pkg::MulBW-1:0] op_b;
  logic signed [tfhn_pkg::ProdW-1:0] prod;
  logic                              div_done;
  logic [tfhn_pkg::NumW-1:0]         quot;

  // derived values
  logic signed [15:0] plo [4];
  logic signed [15:0] phx [4];
  logic signed [15:0] ev [3];
  logic signed [16:0] dx, dz;
  logic [1:0]         area_ti;
  logic [31:0]        acc_sum, mag_sum, num_val;
  logic               area_neg;
  logic [3:0]         sh;
  logic signed [31:0] ps;
  logic signed [32:0] cval;
  logic [IdxW-1:0]    tidx;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  // area number of an edge-area term
  function automatic logic [1:0] area_k(input logic [3:0] n);
    case (n)
      4'd3, 4'd4, 4'd5: area_k = 2'd1;
      4'd6, 4'd7, 4'd8: area_k = 2'd2;
      default:          area_k = 2'd0;
    endcase
  endfunction

  // term number within its area
  function automatic logic [1:0] area_i(input logic [3:0] n);
    case (n)
      4'd1, 4'd4, 4'd7: area_i = 2'd1;
      4'd2, 4'd5, 4'd8: area_i = 2'd2;
      default:          area_i = 2'd0;
    endcase
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  // packed points: low half is z, high half is x less the borrow from a negative z
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      plo[p] = vert[p][2];
      phx[p] = vert[p][0] - {15'd0, vert[p][2][15]};
    end
    plo[3] = qz;
    phx[3] = qx - {15'd0, qz[15]};
    for (int c = 0; c < 3; c++) begin
      ev[c] = (esel ? vert[2][c] : vert[1][c]) - vert[0][c];
    end
  end

  assign dx = 17'(qx) - 17'(vert[0][0]);
  assign dz = 17'(qz) - 17'(vert[0][2]);

  // consume side of the shared multiplier
  assign area_ti  = area_i(tag);
  assign acc_sum  = ((area_ti == 2'd0) ? 32'd0 : acc) + prod[31:0];
  assign area_neg = (area_ti == 2'd2) && acc_sum[31];
  assign mag_sum  = ((tag == 4'd0) ? 32'd0 : mag) + prod[31:0];
  assign sh       = 4'd15 - k;
  assign ps       = $signed(prod[31:0]) >>> sh;
  assign cval     = 33'(tmp) - 33'($signed(prod[31:0]));
  assign num_val  = 32'd0 - pl - prod[31:0];
  assign tidx     = IdxW'(w[31:24] - 8'd64);

  // operand selection for the shared multiplier
  always_comb begin
    logic [1:0] ak, ai, p0, p1, pi, pj, pk, ci, xi, xj, xk;
    ak = area_k(cnt);
    ai = area_i(cnt);
    p0 = ak;
    p1 = inc3(ak);
    pi = (ai == 2'd0) ? p0 : (ai == 2'd1) ? p1 : 2'd3;
    pj = (ai == 2'd0) ? p1 : (ai == 2'd1) ? 2'd3 : p0;
    pk = (ai == 2'd0) ? 2'd3 : (ai == 2'd1) ? p0 : p1;
    ci = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];
    xi = (cnt[2:1] == 2'd3) ? 2'd0 : cnt[2:1];
    xj = inc3(xi);
    xk = inc3(xj);
    op_a = '0;
    op_b = '0;
    case (state)
      tfhn_pkg::ST_AREA: begin
        op_a = tfhn_pkg::MulAW'(plo[pi]);
        op_b = tfhn_pkg::MulBW'(phx[pj]) - tfhn_pkg::MulBW'(phx[pk]);
      end
      tfhn_pkg::ST_MAG: begin
        op_a = tfhn_pkg::MulAW'(ev[ci]);
        op_b = tfhn_pkg::MulBW'(ev[ci]);
      end
      tfhn_pkg::ST_SCALE: begin
        op_a = tfhn_pkg::MulAW'(rdata);
        op_b = tfhn_pkg::MulBW'(ev[ci]);
      end
      tfhn_pkg::ST_CROSS: begin
        if (cnt[0]) begin
          op_a = tfhn_pkg::MulAW'(nab[xk]);
          op_b = tfhn_pkg::MulBW'(nac[xj]);
        end else begin
          op_a = tfhn_pkg::MulAW'(nab[xj]);
          op_b = tfhn_pkg::MulBW'(nac[xk]);
        end
      end
      tfhn_pkg::ST_PLANE: begin
        op_a = cnt[0] ? nrm[2] : nrm[0];
        op_b = cnt[0] ? dz : dx;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  tfhn_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  tfhn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ($signed(num_val)),
    .den   (nrm[1]),
    .done  (div_done),
    .quot  (quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfhn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer strobes
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    phase_end     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    last_tag      = 4'd0;
    case (state)
      tfhn_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && cmd == tfhn_pkg::CMD_EVAL) state_next = tfhn_pkg::ST_AREA;
      end
      tfhn_pkg::ST_AREA: begin
        last_tag = 4'd8;
        issue    = cnt <= last_tag;
        if (pend && tag == last_tag) begin
          phase_end  = 1'b1;
          state_next = (in_tri && !area_neg) ? tfhn_pkg::ST_MAG : tfhn_pkg::ST_FIN;
        end
      end
      tfhn_pkg::ST_MAG: begin
        last_tag = 4'd2;
        issue    = cnt <= last_tag;
        if (pend && tag == last_tag) begin
          phase_end = 1'b1;
          if (mag_sum == 32'd0) begin
            state_next = esel ? tfhn_pkg::ST_CROSS : tfhn_pkg::ST_MAG;
          end else if (mag_sum[31]) begin
            state_next = tfhn_pkg::ST_FIN;
          end else begin
            state_next = tfhn_pkg::ST_NORM;
          end
        end
      end
      tfhn_pkg::ST_NORM: begin
        if (w[31:30] != 2'd0) state_next = tfhn_pkg::ST_TRD;
      end
      tfhn_pkg::ST_TRD: begin
        state_next = tfhn_pkg::ST_SCALE;
      end
      tfhn_pkg::ST_SCALE: begin
        last_tag = 4'd2;
        issue    = cnt <= last_tag;
        if (pend && tag == last_tag) begin
          phase_end  = 1'b1;
          state_next = esel ? tfhn_pkg::ST_CROSS : tfhn_pkg::ST_MAG;
        end
      end
      tfhn_pkg::ST_CROSS: begin
        last_tag = 4'd5;
        issue    = cnt <= last_tag;
        if (pend && tag == last_tag) begin
          phase_end  = 1'b1;
          state_next = (nrm[1] == 21'sd0) ? tfhn_pkg::ST_FIN : tfhn_pkg::ST_PLANE;
        end
      end
      tfhn_pkg::ST_PLANE: begin
        last_tag = 4'd1;
        issue    = cnt <= last_tag;
        if (pend && tag == last_tag) begin
          phase_end  = 1'b1;
          div_start  = 1'b1;
          state_next = tfhn_pkg::ST_DIV;
        end
      end
      tfhn_pkg::ST_DIV: begin
        if (div_done) state_next = tfhn_pkg::ST_FIN;
      end
      tfhn_pkg::ST_FIN: begin
        if (!m_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = tfhn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tfhn_pkg::ST_IDLE;
      end
    endcase
  end

  // issue counter, product tracking and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      pend    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (state == tfhn_pkg::ST_IDLE || phase_end) begin
        cnt  <= '0;
        pend <= 1'b0;
      end else begin
        pend <= issue;
        if (issue) cnt <= cnt + 4'd1;
      end
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // reciprocal table, registered read at the normalised index
  always_ff @(posedge clk) begin
    if (accept && cmd == tfhn_pkg::CMD_TABLE && {1'b0, table_slot} < 9'(TABLE_DEPTH)) begin
      recip_mem[table_slot[IdxW-1:0]] <= table_word;
    end
    rdata <= recip_mem[tidx];
  end

  // datapath
  always_ff @(posedge clk) begin
    tag <= cnt;
    case (state)
      tfhn_pkg::ST_IDLE: begin
        if (accept && cmd == tfhn_pkg::CMD_VERTEX && vertex_slot != 2'd3) begin
          vert[vertex_slot][0] <= corner_x;
          vert[vertex_slot][1] <= corner_y;
          vert[vertex_slot][2] <= corner_z;
        end
        if (accept && cmd == tfhn_pkg::CMD_EVAL) begin
          qx       <= query_x;
          qz       <= query_z;
          in_tri   <= 1'b1;
          fault    <= 1'b0;
          height_r <= '0;
          esel     <= 1'b0;
          for (int c = 0; c < 3; c++) nrm[c] <= '0;
        end
      end
      tfhn_pkg::ST_AREA: begin
        if (pend) begin
          acc <= acc_sum;
          if (area_neg) in_tri <= 1'b0;
        end
      end
      tfhn_pkg::ST_MAG: begin
        if (pend) begin
          mag <= mag_sum;
          if (tag == 4'd2) begin
            if (mag_sum == 32'd0) begin
              // zero-length edge normalises to zero
              for (int c = 0; c < 3; c++) begin
                if (esel) nac[c] <= '0;
                else      nab[c] <= '0;
              end
              esel <= 1'b1;
            end else if (mag_sum[31]) begin
              fault <= 1'b1;
            end else begin
              w <= mag_sum;
              k <= '0;
            end
          end
        end
      end
      tfhn_pkg::ST_NORM: begin
        // even shift search: whole bytes first, then pairs of bits
        if (w[31:30] == 2'd0) begin
          if (w[31:24] == 8'd0) begin
            w <= {w[23:0], 8'd0};
            k <= k + 4'd4;
          end else begin
            w <= {w[29:0], 2'd0};
            k <= k + 4'd1;
          end
        end
      end
      tfhn_pkg::ST_SCALE: begin
        if (pend) begin
          if (esel) nac[tag[1:0]] <= ps[15:0];
          else      nab[tag[1:0]] <= ps[15:0];
          if (tag == 4'd2) esel <= 1'b1;
        end
      end
      tfhn_pkg::ST_CROSS: begin
        if (pend) begin
          if (!tag[0]) tmp <= $signed(prod[31:0]);
          else         nrm[tag[2:1]] <= cval[32:12];
        end
      end
      tfhn_pkg::ST_PLANE: begin
        if (pend && tag == 4'd0) pl <= prod[31:0];
      end
      tfhn_pkg::ST_DIV: begin
        if (div_done) height_r <= vert[0][1] + quot[15:0];
      end
      tfhn_pkg::ST_FIN: begin
        if (out_load) begin
          m_data <= {7'd0, fault, nrm[2], nrm[1], nrm[0], height_r, in_tri};
        end
      end
      default: begin
        tmp <= tmp;
      end
    endcase
  end

endmodule

// File: rtl/tfhn_mul.sv
// shared signed multiplier with a registered product
// depends on tfhn_pkg for operand widths
module tfhn_mul (
  input  logic                                clk,
  input  logic signed [tfhn_pkg::MulAW-1:0]   a,
  input  logic signed [tfhn_pkg::MulBW-1:0]   b,
  output logic signed [tfhn_pkg::ProdW-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= tfhn_pkg::ProdW'(a) * tfhn_pkg::ProdW'(b);
  end

endmodule

// File: rtl/tfhn_div.sv
// iterative signed divider, one quotient bit a cycle, truncating toward zero
// depends on tfhn_pkg for operand widths
module tfhn_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [tfhn_pkg::NumW-1:0]   num,
  input  logic signed [tfhn_pkg::DenW-1:0]   den,
  output logic                               done,
  output logic [tfhn_pkg::NumW-1:0]          quot
);

  localparam int CntW = $clog2(tfhn_pkg::NumW);

  logic                        busy;
  logic [CntW-1:0]             cnt;
  logic [tfhn_pkg::DenW-1:0]   rem;
  logic [tfhn_pkg::DenW-1:0]   dmag;
  logic [tfhn_pkg::NumW-1:0]   quo;
  logic                        neg;
  logic [tfhn_pkg::DenW:0]     rsh;
  logic                        ge;
  logic [tfhn_pkg::DenW:0]     rdiff;

  assign rsh   = {rem, quo[tfhn_pkg::NumW-1]};
  assign ge    = rsh >= {1'b0, dmag};
  assign rdiff = rsh - {1'b0, dmag};
  assign quot  = neg ? (tfhn_pkg::NumW'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(tfhn_pkg::NumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num[tfhn_pkg::NumW-1] ? (tfhn_pkg::NumW'(0) - num) : num;
      dmag <= den[tfhn_pkg::DenW-1] ? (tfhn_pkg::DenW'(0) - den) : den;
      neg  <= num[tfhn_pkg::NumW-1] ^ den[tfhn_pkg::DenW-1];
    end else if (busy) begin
      rem <= ge ? rdiff[tfhn_pkg::DenW-1:0] : rsh[tfhn_pkg::DenW-1:0];
      quo <= {quo[tfhn_pkg::NumW-2:0], ge};
    end
  end

endmodule
